[hw/rtl/rar_pkg.sv]
// Package for the rational arithmetic reducer: payload structs, opcodes,
// controller states and the command/status bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rar_pkg;

    localparam int OperandWidth = 16;
    localparam int NumBits = 33;
    localparam int DenBits = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]              action;
        logic [OperandWidth-1:0] a_num;
        logic [OperandWidth-1:0] a_den;
        logic [OperandWidth-1:0] b_num;
        logic [OperandWidth-1:0] b_den;
    } in_word_t;

    typedef struct packed {
        logic [NumBits-1:0] result_num;
        logic [DenBits-1:0] result_den;
        logic               den_zero;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic gcd_start;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic div_sel_den;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic den_zero;
        logic num_zero;
        logic gcd_done;
        logic div_done;
    } stat_t;

endpackage
`default_nettype wire

[hw/rtl/rar_ctrl.sv]
// Controller state machine for the rational reducer.
// Depends on rar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rar_ctrl
    import rar_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  wire logic  out_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum = 1'b1;
                cmd.gcd_start = 1'b1;
                state_next = ST_GCD;
            end
            ST_GCD:
            begin
                if (stat.den_zero || stat.num_zero)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
                else if (stat.gcd_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIVN;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIVN:
            begin
                if (stat.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel_den = 1'b1;
                    state_next = ST_DIVD;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_DIVD:
            begin
                cmd.div_sel_den = 1'b1;
                if (stat.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/rar_dp.sv]
// Datapath for the rational reducer: cross products, binary GCD and a
// restoring divider shared for numerator and denominator.
// Depends on rar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rar_dp
    import rar_pkg::*;
(
    input  wire logic     clk,
    input  wire in_word_t in_word,
    input  wire cmd_t     cmd,
    output stat_t         stat,
    output out_word_t     out_word
);

    localparam int PW = 2 * OperandWidth;
    localparam int SW = PW + 1;
    localparam int MW = PW + 1;
    localparam int CW = $clog2(MW + 1);

    logic [1:0]                       op_reg;
    logic signed [OperandWidth-1:0]   an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0]             p0_reg, p1_reg, pd_reg;
    logic signed [SW-1:0]             num_reg;
    logic signed [PW-1:0]             den_reg;
    logic                             neg_reg;
    logic [MW-1:0]                    mn_reg, md_reg;
    logic [MW-1:0]                    gx_reg, gy_reg;
    logic [CW-1:0]                    sh_reg;
    logic [MW-1:0]                    quo_reg, rem_reg;
    logic [CW-1:0]                    cnt_reg;
    logic [MW-1:0]                    qn_reg;
    out_word_t                        out_reg;

    logic signed [SW-1:0] sum_next;
    logic [MW-1:0]        mag_num, mag_den, gx_next, gy_next, gval;
    logic [MW:0]          trial;
    logic                 gx_even, gy_even;

    // Sign-magnitude of the raw fraction.
    assign mag_num = num_reg[SW-1] ? MW'(-num_reg) : MW'(num_reg);
    assign mag_den = den_reg[PW-1] ? MW'(-$signed({den_reg[PW-1], den_reg}))
                                   : MW'($signed({den_reg[PW-1], den_reg}));

    // Status.
    assign stat.den_zero = (den_reg == '0);
    assign stat.num_zero = (num_reg == '0);
    assign stat.gcd_done = (gy_reg == '0);
    assign stat.div_done = (cnt_reg == '0);

    // Numerator: sum or difference of the cross products, or the first product alone for multiply and divide.
    always_comb
    begin
        case (op_t'(op_reg))
            OP_ADD:  sum_next = SW'(p0_reg) + SW'(p1_reg);
            OP_SUB:  sum_next = SW'(p0_reg) - SW'(p1_reg);
            default: sum_next = SW'(p0_reg);
        endcase
    end

    // One binary-GCD step: halve each even value, else subtract the smaller and halve.
    always_comb
    begin
        gx_even = ~gx_reg[0];
        gy_even = ~gy_reg[0];
        gx_next = gx_reg;
        gy_next = gy_reg;
        if (gx_even && gy_even)
        begin
            gx_next = gx_reg >> 1;
            gy_next = gy_reg >> 1;
        end
        else if (gx_even)
        begin
            gx_next = gx_reg >> 1;
        end
        else if (gy_even)
        begin
            gy_next = gy_reg >> 1;
        end
        else if (gx_reg >= gy_reg)
        begin
            gx_next = (gx_reg - gy_reg) >> 1;
        end
        else
        begin
            gy_next = (gy_reg - gx_reg) >> 1;
        end
        if (gx_next == '0)
        begin
            gx_next = gy_next;
            gy_next = '0;
        end
    end

    // GCD value with the common power of two restored.
    assign gval = gx_reg << sh_reg;
    assign trial = {rem_reg, quo_reg[MW-1]} - {1'b0, gval};

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_word.action;
            an_reg <= in_word.a_num;
            ad_reg <= in_word.a_den;
            bn_reg <= in_word.b_num;
            bd_reg <= in_word.b_den;
        end
        if (cmd.mul)
        begin
            if (op_t'(op_reg) == OP_MUL)
            begin
                p0_reg <= PW'(an_reg) * PW'(bn_reg);
                pd_reg <= PW'(ad_reg) * PW'(bd_reg);
            end
            else if (op_t'(op_reg) == OP_DIV)
            begin
                p0_reg <= PW'(an_reg) * PW'(bd_reg);
                pd_reg <= PW'(ad_reg) * PW'(bn_reg);
            end
            else
            begin
                p0_reg <= PW'(an_reg) * PW'(bd_reg);
                pd_reg <= PW'(ad_reg) * PW'(bd_reg);
            end
            p1_reg <= PW'(ad_reg) * PW'(bn_reg);
        end
        if (cmd.sum)
        begin
            num_reg <= sum_next;
            den_reg <= pd_reg;
        end
        if (cmd.gcd_start)
        begin
            neg_reg <= 1'b0;
            sh_reg <= '0;
        end
        // The GCD registers load from the sum in the next state's first step.
        if (cmd.gcd_step)
        begin
            if (gx_reg == '0 && gy_reg == '1)
            begin
                gx_reg <= mag_num;
                gy_reg <= mag_den;
                mn_reg <= mag_num;
                md_reg <= mag_den;
                neg_reg <= num_reg[SW-1] ^ den_reg[PW-1];
            end
            else
            begin
                gx_reg <= gx_next;
                gy_reg <= gy_next;
                if (~gx_reg[0] && ~gy_reg[0])
                begin
                    sh_reg <= sh_reg + 1'b1;
                end
            end
        end
        if (cmd.gcd_start)
        begin
            gx_reg <= '0;
            gy_reg <= '1;
        end
        if (cmd.div_start)
        begin
            if (!cmd.div_sel_den)
            begin
                quo_reg <= mn_reg;
            end
            else
            begin
                qn_reg <= quo_reg;
                quo_reg <= md_reg;
            end
            rem_reg <= '0;
            cnt_reg <= CW'(MW);
        end
        else if (cmd.div_step)
        begin
            if (!trial[MW])
            begin
                rem_reg <= trial[MW-1:0];
                quo_reg <= {quo_reg[MW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[MW-2:0], quo_reg[MW-1]};
                quo_reg <= {quo_reg[MW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.finish)
        begin
            if (stat.den_zero)
            begin
                out_reg.result_num <= NumBits'(num_reg);
                out_reg.result_den <= '0;
                out_reg.den_zero <= 1'b1;
            end
            else if (stat.num_zero)
            begin
                out_reg.result_num <= '0;
                out_reg.result_den <= DenBits'(1);
                out_reg.den_zero <= 1'b0;
            end
            else
            begin
                out_reg.result_num <= neg_reg ? NumBits'(-{1'b0, qn_reg})
                                              : NumBits'({1'b0, qn_reg});
                out_reg.result_den <= DenBits'(quo_reg);
                out_reg.den_zero <= 1'b0;
            end
        end
    end

    assign out_word = out_reg;

endmodule
`default_nettype wire

[hw/rtl/rational_arith_reduce.sv]
// Rational arithmetic with GCD reduction, one word at a time (operand width W).
// From input accept to output valid: products, then the sum, then loading of the GCD,
// the binary-GCD steps, a check that sees the GCD end, then two restoring divisions.
// Zero denominators or numerators skip the GCD steps and the divides. A new word is
// taken only after the last one has been handed off at the output and the controller
// is back in idle. Async reset to idle.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_reduce
    import rar_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_word_t in_word,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_word_t     out_word
);

    cmd_t  cmd;
    stat_t stat;

    rar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rar_dp u_dp (
        .clk      (clk),
        .in_word  (in_word),
        .cmd      (cmd),
        .stat     (stat),
        .out_word (out_word)
    );

    // A flagged zero denominator always reports a zero denominator field.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.den_zero |-> out_word.result_den == '0)
        else $error("den_zero with nonzero denominator");

    // The input is never taken while a word waits at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while output pending");

    // A reduced result has a nonzero denominator.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.den_zero |-> out_word.result_den != '0)
        else $error("reduced result has zero denominator");

endmodule
`default_nettype wire
